FILE: hdl/dpbm_pkg.sv
// shared types and constants for the depth plane band marker
// no dependencies; imported by every module of the block
`default_nettype none

package dpbm_pkg;

    localparam int ADDR_W    = 5;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam logic [7:0] MARK_ADD = 8'd127;

    typedef enum logic [2:0] {
        REG_COEFF_U      = 3'd0,
        REG_COEFF_V      = 3'd1,
        REG_NORMAL_Z     = 3'd2,
        REG_PLANE_OFFSET = 3'd3,
        REG_CENTER_COL   = 3'd4,
        REG_CENTER_ROW   = 3'd5,
        REG_NEAR_BAND    = 3'd6,
        REG_MASK_MISSING = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        CLS_PASS     = 2'd0,
        CLS_NO_DEPTH = 2'd1,
        CLS_MEASURE  = 2'd2
    } cls_t;

    typedef struct packed {
        logic        frame_start;
        logic [9:0]  col;
        logic [9:0]  row;
        logic [15:0] depth;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } pix_t;

    typedef struct packed {
        logic [7:0]  out_blue;
        logic [7:0]  out_green;
        logic [7:0]  out_red;
        logic        on_plane;
        logic [30:0] max_height;
        logic [9:0]  max_col;
        logic [9:0]  max_row;
    } res_t;

    typedef struct packed {
        logic [31:0] coeff_u;
        logic [31:0] coeff_v;
        logic [31:0] normal_z;
        logic [31:0] plane_offset;
        logic [13:0] center_col;
        logic [13:0] center_row;
        logic [30:0] near_band;
        logic        mask_missing;
    } cfg_t;

    typedef struct packed {
        logic        frame_start;
        logic [9:0]  col;
        logic [9:0]  row;
        logic [15:0] depth;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        cls_t        cls;
    } meta_t;

    typedef struct packed {
        meta_t       meta;
        logic [46:0] pu;
        logic [46:0] pv;
    } qent_t;

endpackage

`default_nettype wire

FILE: hdl/dpbm_regs.sv
// configuration register file behind the apb port
// depends on dpbm_pkg
`default_nettype none

module dpbm_regs
    import dpbm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_COEFF_U:      cfg_next.coeff_u      = pwdata;
                REG_COEFF_V:      cfg_next.coeff_v      = pwdata;
                REG_NORMAL_Z:     cfg_next.normal_z     = pwdata;
                REG_PLANE_OFFSET: cfg_next.plane_offset = pwdata;
                REG_CENTER_COL:   cfg_next.center_col   = pwdata[13:0];
                REG_CENTER_ROW:   cfg_next.center_row   = pwdata[13:0];
                REG_NEAR_BAND:    cfg_next.near_band    = pwdata[30:0];
                REG_MASK_MISSING: cfg_next.mask_missing = pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_COEFF_U:      prdata = cfg_reg.coeff_u;
            REG_COEFF_V:      prdata = cfg_reg.coeff_v;
            REG_NORMAL_Z:     prdata = cfg_reg.normal_z;
            REG_PLANE_OFFSET: prdata = cfg_reg.plane_offset;
            REG_CENTER_COL:   prdata = 32'(cfg_reg.center_col);
            REG_CENTER_ROW:   prdata = 32'(cfg_reg.center_row);
            REG_NEAR_BAND:    prdata = 32'(cfg_reg.near_band);
            REG_MASK_MISSING: prdata = 32'(cfg_reg.mask_missing);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coeff_u      <= 32'd0;
            cfg_reg.coeff_v      <= 32'd0;
            cfg_reg.normal_z     <= 32'd1073741824;
            cfg_reg.plane_offset <= 32'd0;
            cfg_reg.center_col   <= 14'd5120;
            cfg_reg.center_row   <= 14'd3840;
            cfg_reg.near_band    <= 31'd0;
            cfg_reg.mask_missing <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dpbm_front.sv
// front end: takes a pixel word, classifies it and forms the column and row products
// depends on dpbm_pkg
`default_nettype none

module dpbm_front
    import dpbm_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  wire pix_t  pix,
    input  wire cfg_t  cfg,
    output qent_t      ent
);

    logic signed [14:0] u;
    logic signed [14:0] v;
    logic               in_frame;

    assign u = $signed({1'b0, cfg.center_col}) - $signed({1'b0, pix.col, 4'b0000});
    assign v = $signed({1'b0, cfg.center_row}) - $signed({1'b0, pix.row, 4'b0000});
    assign in_frame = (32'(pix.col) < MAX_COLS) && (32'(pix.row) < MAX_ROWS);

    always_comb
    begin
        ent.meta.frame_start = pix.frame_start;
        ent.meta.col         = pix.col;
        ent.meta.row         = pix.row;
        ent.meta.depth       = pix.depth;
        ent.meta.blue        = pix.blue;
        ent.meta.green       = pix.green;
        ent.meta.red         = pix.red;
        priority if (!in_frame)
            ent.meta.cls = CLS_PASS;
        else if (pix.depth == 16'd0)
            ent.meta.cls = CLS_NO_DEPTH;
        else
            ent.meta.cls = CLS_MEASURE;
        ent.pu = $signed(cfg.coeff_u) * u;
        ent.pv = $signed(cfg.coeff_v) * v;
    end

endmodule

`default_nettype wire

FILE: hdl/dpbm_queue.sv
// short first-in first-out queue between front and back
// depends on dpbm_pkg
`default_nettype none

module dpbm_queue
    import dpbm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire qent_t wdata,
    input  wire logic  pop,
    output qent_t      rdata,
    output logic       full,
    output logic       empty
);

    qent_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dpbm_back.sv
// back end: distance pipeline, band test, running maximum and output register
// depends on dpbm_pkg
`default_nettype none

module dpbm_back
    import dpbm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire qent_t head,
    input  wire logic  empty,
    output logic       pop,
    output logic       res_valid,
    input  wire logic  res_stall,
    output res_t       res
);

    localparam logic signed [44:0] HEIGHT_MAX = $signed({14'd0, {31{1'b1}}});

    logic               advance;
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    meta_t              m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [48:0] s1_reg;
    logic signed [48:0] s1_next;
    logic        [47:0] lo2_reg;
    logic        [47:0] lo2_next;
    logic signed [33:0] hi2_reg;
    logic signed [33:0] hi2_next;
    logic signed [65:0] prod;
    logic signed [43:0] p3_reg;
    logic signed [43:0] p3_next;
    logic signed [44:0] h4_reg;
    logic signed [44:0] h4_next;
    logic signed [44:0] band_s;
    logic               near;
    logic               beat;
    logic        [30:0] h_sat;
    logic        [30:0] best_cur;
    logic        [30:0] best_h_reg;
    logic        [30:0] best_h_next;
    logic        [9:0]  best_c_reg;
    logic        [9:0]  best_c_next;
    logic        [9:0]  best_r_reg;
    logic        [9:0]  best_r_next;
    logic        [8:0]  red_sum;
    res_t               res_reg;
    res_t               res_next;
    logic               res_valid_reg;

    assign advance   = !res_valid_reg || !res_stall;
    assign pop       = advance && !empty;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // distance arithmetic, one wide step a stage
    always_comb
    begin
        s1_next  = $signed(head.pu) + $signed(head.pv) + $signed(cfg.normal_z);
        lo2_next = m1_reg.depth * s1_reg[31:0];
        hi2_next = $signed(s1_reg[48:32]) * $signed({1'b0, m1_reg.depth});
        prod     = $signed({hi2_reg, 32'd0}) + $signed({18'd0, lo2_reg});
        p3_next  = prod[65:22];
        h4_next  = $signed(p3_reg) - $signed(cfg.plane_offset);
    end

    // band test, running maximum and result word
    always_comb
    begin
        band_s   = $signed({14'd0, cfg.near_band});
        near     = h4_reg[44] ? (h4_reg > -band_s) : (h4_reg < band_s);
        best_cur = m4_reg.frame_start ? 31'd0 : best_h_reg;
        h_sat    = (h4_reg > HEIGHT_MAX) ? 31'h7FFFFFFF : h4_reg[30:0];
        beat     = (m4_reg.cls == CLS_MEASURE) && !h4_reg[44] && (h_sat > best_cur);
        red_sum  = {1'b0, m4_reg.red} + {1'b0, MARK_ADD};

        best_h_next = best_cur;
        best_c_next = m4_reg.frame_start ? 10'd0 : best_c_reg;
        best_r_next = m4_reg.frame_start ? 10'd0 : best_r_reg;
        if (beat)
        begin
            best_h_next = h_sat;
            best_c_next = m4_reg.col;
            best_r_next = m4_reg.row;
        end

        res_next.out_blue   = m4_reg.blue;
        res_next.out_green  = m4_reg.green;
        res_next.out_red    = m4_reg.red;
        res_next.on_plane   = 1'b0;
        unique case (m4_reg.cls)
            CLS_MEASURE:
            begin
                if (near)
                begin
                    res_next.on_plane = 1'b1;
                    res_next.out_red  = red_sum[8] ? 8'hFF : red_sum[7:0];
                end
            end
            CLS_NO_DEPTH:
            begin
                if (cfg.mask_missing)
                begin
                    res_next.out_blue  = 8'd0;
                    res_next.out_green = 8'd0;
                    res_next.out_red   = 8'd0;
                end
            end
            default:
            begin
            end
        endcase
        res_next.max_height = best_h_next;
        res_next.max_col    = best_c_next;
        res_next.max_row    = best_r_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m1_reg  <= head.meta;
            s1_reg  <= s1_next;
            m2_reg  <= m1_reg;
            lo2_reg <= lo2_next;
            hi2_reg <= hi2_next;
            m3_reg  <= m2_reg;
            p3_reg  <= p3_next;
            m4_reg  <= m3_reg;
            h4_reg  <= h4_next;
            if (v4_reg)
                res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
            best_h_reg    <= 31'd0;
            best_c_reg    <= 10'd0;
            best_r_reg    <= 10'd0;
        end
        else if (advance)
        begin
            v1_reg        <= !empty;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            res_valid_reg <= v4_reg;
            if (v4_reg)
            begin
                best_h_reg <= best_h_next;
                best_c_reg <= best_c_next;
                best_r_reg <= best_r_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/depth_plane_band_marker.sv
// depth plane band marker: an accepted pixel word passes the queue, the back-end
// distance stages and the output register to become its result word; one word per
// cycle sustained while the output is not stalled; a four-entry queue lets
// the front keep accepting while the output stalls. reset clears the pipeline,
// the queue and the running maximum and loads the register defaults
`default_nettype none

module depth_plane_band_marker
    import dpbm_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              pix_valid,
    output logic                   pix_stall,
    input  wire pix_t              pix,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output res_t                   res
);

    cfg_t  cfg;
    qent_t q_wdata;
    qent_t q_rdata;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;

    assign pix_stall = q_full;

    dpbm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpbm_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .pix (pix),
        .cfg (cfg),
        .ent (q_wdata)
    );

    dpbm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (pix_valid),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    dpbm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (q_rdata),
        .empty     (q_empty),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire

FILE: hdl/dpbm_checker.sv
// port-level checks for the depth plane band marker, bound to the top level
// depends on dpbm_pkg and depth_plane_band_marker
`default_nettype none

module dpbm_checker
    import dpbm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [31:0]       pwdata,
    input wire logic [31:0]       prdata,
    input wire logic              pready,
    input wire logic              pix_valid,
    input wire logic              pix_stall,
    input wire pix_t              pix,
    input wire logic              res_valid,
    input wire logic              res_stall,
    input wire res_t              res
);

    // a stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // a zero maximum always sits at the origin
    a_max_origin: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.max_height == 31'd0) |-> (res.max_col == 10'd0)
            && (res.max_row == 10'd0))
        else $error("zero maximum with nonzero position");

    // a marked pixel carries at least the tint
    a_mark_red: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.on_plane |-> (res.out_red >= MARK_ADD))
        else $error("marked pixel without red tint");

endmodule

bind depth_plane_band_marker dpbm_checker u_checker (.*);

`default_nettype wire
